/* rtl/mm3_pkg.sv */
package mm3_pkg;

    localparam int PC_W = 7;

    localparam logic [PC_W-1:0] PC_TAIL_TWO = 7'd0;
    localparam logic [PC_W-1:0] PC_TAIL_ONE = 7'd9;
    localparam logic [PC_W-1:0] PC_FINAL    = 7'd18;
    localparam logic [PC_W-1:0] PC_BLOCK    = 7'd46;

    localparam logic [63:0] MIX_C1   = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2   = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_K1  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_K2  = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] LANE1_ADD = 64'h0000000052dce729;
    localparam logic [63:0] LANE2_ADD = 64'h0000000038495ab5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD_W,
        OP_LOAD_TAIL,
        OP_LOAD_L1,
        OP_LOAD_L2,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_ROT31,
        OP_ROT33,
        OP_XOR_L1,
        OP_XOR_L2,
        OP_L1_MIX,
        OP_L1_FIN,
        OP_L2_MIX,
        OP_L2_FIN,
        OP_FIN_LEN,
        OP_CROSS1,
        OP_CROSS2,
        OP_FSHIFT,
        OP_STORE_L1,
        OP_STORE_L2,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        CS_C1,
        CS_C2,
        CS_F1,
        CS_F2
    } csel_t;

    typedef enum logic [1:0] {
        FL_SEQ,
        FL_STOP,
        FL_STOP_NOT_LAST
    } flow_t;

    typedef struct packed {
        dp_op_t op;
        csel_t  csel;
        flow_t  flow;
    } ucode_t;

    typedef struct packed {
        logic   accept;
        logic   exec;
        dp_op_t op;
        csel_t  csel;
    } cmd_t;

    typedef struct packed {
        logic held_eff;
        logic in_last;
        logic tail_zero;
        logic tail_full;
        logic last_reg;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = '{op: OP_NOP, csel: CS_C1, flow: FL_SEQ};
        unique case (pc)
            // tail word into lane two
            7'd0:  u.op = OP_LOAD_W;
            7'd1:  u = '{op: OP_MUL_LL, csel: CS_C2, flow: FL_SEQ};
            7'd2:  u = '{op: OP_MUL_LH, csel: CS_C2, flow: FL_SEQ};
            7'd3:  u = '{op: OP_MUL_HL, csel: CS_C2, flow: FL_SEQ};
            7'd4:  u.op = OP_ROT33;
            7'd5:  u = '{op: OP_MUL_LL, csel: CS_C1, flow: FL_SEQ};
            7'd6:  u = '{op: OP_MUL_LH, csel: CS_C1, flow: FL_SEQ};
            7'd7:  u = '{op: OP_MUL_HL, csel: CS_C1, flow: FL_SEQ};
            7'd8:  u.op = OP_XOR_L2;
            // held or tail word into lane one
            7'd9:  u.op = OP_LOAD_TAIL;
            7'd10: u = '{op: OP_MUL_LL, csel: CS_C1, flow: FL_SEQ};
            7'd11: u = '{op: OP_MUL_LH, csel: CS_C1, flow: FL_SEQ};
            7'd12: u = '{op: OP_MUL_HL, csel: CS_C1, flow: FL_SEQ};
            7'd13: u.op = OP_ROT31;
            7'd14: u = '{op: OP_MUL_LL, csel: CS_C2, flow: FL_SEQ};
            7'd15: u = '{op: OP_MUL_LH, csel: CS_C2, flow: FL_SEQ};
            7'd16: u = '{op: OP_MUL_HL, csel: CS_C2, flow: FL_SEQ};
            7'd17: u.op = OP_XOR_L1;
            // finalisation
            7'd18: u.op = OP_FIN_LEN;
            7'd19: u.op = OP_CROSS1;
            7'd20: u.op = OP_CROSS2;
            7'd21: u.op = OP_LOAD_L1;
            7'd22: u.op = OP_FSHIFT;
            7'd23: u = '{op: OP_MUL_LL, csel: CS_F1, flow: FL_SEQ};
            7'd24: u = '{op: OP_MUL_LH, csel: CS_F1, flow: FL_SEQ};
            7'd25: u = '{op: OP_MUL_HL, csel: CS_F1, flow: FL_SEQ};
            7'd26: u.op = OP_FSHIFT;
            7'd27: u = '{op: OP_MUL_LL, csel: CS_F2, flow: FL_SEQ};
            7'd28: u = '{op: OP_MUL_LH, csel: CS_F2, flow: FL_SEQ};
            7'd29: u = '{op: OP_MUL_HL, csel: CS_F2, flow: FL_SEQ};
            7'd30: u.op = OP_FSHIFT;
            7'd31: u.op = OP_STORE_L1;
            7'd32: u.op = OP_LOAD_L2;
            7'd33: u.op = OP_FSHIFT;
            7'd34: u = '{op: OP_MUL_LL, csel: CS_F1, flow: FL_SEQ};
            7'd35: u = '{op: OP_MUL_LH, csel: CS_F1, flow: FL_SEQ};
            7'd36: u = '{op: OP_MUL_HL, csel: CS_F1, flow: FL_SEQ};
            7'd37: u.op = OP_FSHIFT;
            7'd38: u = '{op: OP_MUL_LL, csel: CS_F2, flow: FL_SEQ};
            7'd39: u = '{op: OP_MUL_LH, csel: CS_F2, flow: FL_SEQ};
            7'd40: u = '{op: OP_MUL_HL, csel: CS_F2, flow: FL_SEQ};
            7'd41: u.op = OP_FSHIFT;
            7'd42: u.op = OP_STORE_L2;
            7'd43: u.op = OP_CROSS1;
            7'd44: u.op = OP_CROSS2;
            7'd45: u = '{op: OP_EMIT, csel: CS_C1, flow: FL_STOP};
            // full 16-byte block
            7'd46: u.op = OP_LOAD_TAIL;
            7'd47: u = '{op: OP_MUL_LL, csel: CS_C1, flow: FL_SEQ};
            7'd48: u = '{op: OP_MUL_LH, csel: CS_C1, flow: FL_SEQ};
            7'd49: u = '{op: OP_MUL_HL, csel: CS_C1, flow: FL_SEQ};
            7'd50: u.op = OP_ROT31;
            7'd51: u = '{op: OP_MUL_LL, csel: CS_C2, flow: FL_SEQ};
            7'd52: u = '{op: OP_MUL_LH, csel: CS_C2, flow: FL_SEQ};
            7'd53: u = '{op: OP_MUL_HL, csel: CS_C2, flow: FL_SEQ};
            7'd54: u.op = OP_L1_MIX;
            7'd55: u.op = OP_L1_FIN;
            7'd56: u.op = OP_LOAD_W;
            7'd57: u = '{op: OP_MUL_LL, csel: CS_C2, flow: FL_SEQ};
            7'd58: u = '{op: OP_MUL_LH, csel: CS_C2, flow: FL_SEQ};
            7'd59: u = '{op: OP_MUL_HL, csel: CS_C2, flow: FL_SEQ};
            7'd60: u.op = OP_ROT33;
            7'd61: u = '{op: OP_MUL_LL, csel: CS_C1, flow: FL_SEQ};
            7'd62: u = '{op: OP_MUL_LH, csel: CS_C1, flow: FL_SEQ};
            7'd63: u = '{op: OP_MUL_HL, csel: CS_C1, flow: FL_SEQ};
            7'd64: u.op = OP_L2_MIX;
            7'd65: u = '{op: OP_L2_FIN, csel: CS_C1, flow: FL_STOP_NOT_LAST};
            default: u = '{op: OP_NOP, csel: CS_C1, flow: FL_STOP};
        endcase
        return u;
    endfunction

endpackage

/* rtl/mm3_ctrl.sv */
module mm3_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mm3_pkg::status_t  st,
    output mm3_pkg::cmd_t     cmd
);
    import mm3_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    ucode_t            uc;

    always_comb begin
        uc         = ucode_rom(pc_reg);
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        cmd.op     = uc.op;
        cmd.csel   = uc.csel;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (st.in_last) begin
                        state_next = ST_RUN;
                        if (st.held_eff) begin
                            if (st.tail_full)
                                pc_next = PC_BLOCK;
                            else if (st.tail_zero)
                                pc_next = PC_TAIL_ONE;
                            else
                                pc_next = PC_TAIL_TWO;
                        end else begin
                            pc_next = st.tail_zero ? PC_FINAL : PC_TAIL_ONE;
                        end
                    end else if (st.held_eff) begin
                        state_next = ST_RUN;
                        pc_next    = PC_BLOCK;
                    end
                end
            end
            ST_RUN: begin
                // the emit step waits for room in the result register
                if (uc.op != OP_EMIT || st.out_free) begin
                    cmd.exec = 1'b1;
                    unique case (uc.flow)
                        FL_SEQ:  pc_next = pc_reg + 7'd1;
                        FL_STOP: state_next = ST_IDLE;
                        FL_STOP_NOT_LAST: begin
                            if (st.last_reg)
                                pc_next = PC_FINAL;
                            else
                                state_next = ST_IDLE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_TAIL_TWO;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

/* rtl/mm3_dp.sv */
module mm3_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [63:0]       cfg_data,
    input  logic [63:0]       s_word,
    input  logic [3:0]        s_bytes_valid,
    input  logic              s_last_word,
    input  mm3_pkg::cmd_t     cmd,
    output mm3_pkg::status_t  st,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_hash_low,
    output logic [63:0]       m_hash_high
);
    import mm3_pkg::*;

    logic [63:0] seed_reg;
    logic        in_message_reg;
    logic        held_valid_reg;
    logic        m_valid_reg;
    logic [63:0] lane1_reg, lane2_reg;
    logic [63:0] held_word_reg, word_reg;
    logic [31:0] total_reg;
    logic        last_reg;
    logic [63:0] x_reg, p_reg;
    logic [63:0] out_low_reg, out_high_reg;

    logic [3:0]  n_eff;
    logic [63:0] word_mask;
    logic        held_eff;
    logic [63:0] cst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] l1_xor, l2_xor;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
        return (v << s) | (v >> (64 - s));
    endfunction

    always_comb begin
        // a short count only counts on the last word
        n_eff     = (s_last_word && s_bytes_valid <= 4'd8) ? s_bytes_valid : 4'd8;
        word_mask = n_eff[3] ? {64{1'b1}}
                             : ((64'd1 << {n_eff[2:0], 3'b000}) - 64'd1);
        held_eff  = in_message_reg && held_valid_reg;
        unique case (cmd.csel)
            CS_C1:   cst = MIX_C1;
            CS_C2:   cst = MIX_C2;
            CS_F1:   cst = FMIX_K1;
            CS_F2:   cst = FMIX_K2;
            default: cst = MIX_C1;
        endcase
        // one 32x32 multiplier, three passes give the low 64 bits
        mul_a  = (cmd.op == OP_MUL_HL) ? x_reg[63:32] : x_reg[31:0];
        mul_b  = (cmd.op == OP_MUL_LH) ? cst[63:32] : cst[31:0];
        mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
        l1_xor = lane1_reg ^ x_reg;
        l2_xor = lane2_reg ^ x_reg;
    end

    always_comb begin
        st.held_eff  = held_eff;
        st.in_last   = s_last_word;
        st.tail_zero = (n_eff == 4'd0);
        st.tail_full = n_eff[3];
        st.last_reg  = last_reg;
        st.out_free  = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= 64'd0;
            in_message_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid)
                seed_reg <= cfg_data;
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (cmd.accept) begin
                in_message_reg <= 1'b1;
                held_valid_reg <= (!s_last_word && !held_eff) ? 1'b1 : held_eff;
            end
            if (cmd.exec && cmd.op == OP_L2_FIN)
                held_valid_reg <= 1'b0;
            if (cmd.exec && cmd.op == OP_EMIT) begin
                m_valid_reg    <= 1'b1;
                in_message_reg <= 1'b0;
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            word_reg <= s_word & word_mask;
            last_reg <= s_last_word;
            if (!in_message_reg) begin
                lane1_reg <= seed_reg;
                lane2_reg <= seed_reg;
                total_reg <= {28'd0, n_eff};
            end else begin
                total_reg <= total_reg + {28'd0, n_eff};
            end
            if (!s_last_word && !held_eff)
                held_word_reg <= s_word;
        end
        if (cmd.exec) begin
            unique case (cmd.op)
                OP_LOAD_W:    x_reg <= word_reg;
                OP_LOAD_TAIL: x_reg <= held_valid_reg ? held_word_reg : word_reg;
                OP_LOAD_L1:   x_reg <= lane1_reg;
                OP_LOAD_L2:   x_reg <= lane2_reg;
                OP_MUL_LL:    p_reg <= mul_p;
                OP_MUL_LH:    p_reg[63:32] <= p_reg[63:32] + mul_p[31:0];
                OP_MUL_HL:    x_reg <= {p_reg[63:32] + mul_p[31:0], p_reg[31:0]};
                OP_ROT31:     x_reg <= rotl(x_reg, 31);
                OP_ROT33:     x_reg <= rotl(x_reg, 33);
                OP_XOR_L1:    lane1_reg <= l1_xor;
                OP_XOR_L2:    lane2_reg <= l2_xor;
                OP_L1_MIX:    lane1_reg <= rotl(l1_xor, 27) + lane2_reg;
                OP_L1_FIN:    lane1_reg <= (lane1_reg << 2) + lane1_reg + LANE1_ADD;
                OP_L2_MIX:    lane2_reg <= rotl(l2_xor, 31) + lane1_reg;
                OP_L2_FIN:    lane2_reg <= (lane2_reg << 2) + lane2_reg + LANE2_ADD;
                OP_FIN_LEN: begin
                    lane1_reg <= lane1_reg ^ {32'd0, total_reg};
                    lane2_reg <= lane2_reg ^ {32'd0, total_reg};
                end
                OP_CROSS1:    lane1_reg <= lane1_reg + lane2_reg;
                OP_CROSS2:    lane2_reg <= lane2_reg + lane1_reg;
                OP_FSHIFT:    x_reg <= x_reg ^ (x_reg >> 33);
                OP_STORE_L1:  lane1_reg <= x_reg;
                OP_STORE_L2:  lane2_reg <= x_reg;
                OP_EMIT: begin
                    out_low_reg  <= lane1_reg;
                    out_high_reg <= lane2_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hash_low  = out_low_reg;
    assign m_hash_high = out_high_reg;

endmodule

/* rtl/murmur3_128bit_hash.sv */
// MurmurHash3 x64 128-bit streaming hash.
// Input channel s_*: one 64-bit little-endian word per item with a count of
// valid low bytes (s_bytes_valid) and a last-word flag. Counts below eight
// only matter on the last word. Result channel m_*: one 128-bit hash per
// message, issued after its last word. cfg_*: seed write, taken any cycle,
// used when the next message starts.
// Sequencing: the first word of a 16-byte block is only stored; the second word
// runs the block mix in 20 micro-steps. A last word runs any tail steps, then
// the finalisation (after the block mix when it completes a full block), and
// its emit step waits for room in the result register. The rate is set by a
// single shared 32x32 multiplier: each 64-bit constant multiply is three passes
// through it, sequenced by a microcoded controller.
// Reset (aresetn low, synchronous) clears the seed to zero, drops any message
// in progress and empties the result register.
// A result waits in the output register while m_ready is low; the block keeps
// taking words meanwhile and only holds at the emit step of the next message.
module murmur3_128bit_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_word,
    input  logic [3:0]  s_bytes_valid,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_low,
    output logic [63:0] m_hash_high
);
    import mm3_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    mm3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mm3_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_word        (s_word),
        .s_bytes_valid (s_bytes_valid),
        .s_last_word   (s_last_word),
        .cmd           (cmd),
        .st            (st),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_low    (m_hash_low),
        .m_hash_high   (m_hash_high)
    );

endmodule

/* rtl/mm3_checker.sv */
module mm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_word,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_hash_low,
    input logic [63:0] m_hash_high
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hash_low) && $stable(m_hash_high)))
        else $error("result changed while stalled");

    // a result never appears the cycle after an item is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result raised straight after an item");

    // the last word keeps the input closed while it is finalised
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_word) |=> !s_ready)
        else $error("input open during finalisation");

    // out of reset the block is empty and ready
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("bad state after reset");

endmodule

bind murmur3_128bit_hash mm3_checker u_mm3_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last_word (s_last_word),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hash_low  (m_hash_low),
    .m_hash_high (m_hash_high)
);
